// ----- rtl/core/gri_pkg.sv -----
// shared types, widths and constants of the gyro rate integrator
package gri_pkg;

	// field and datapath widths
	localparam int RAW_W      = 16;
	localparam int TIMER_W    = 16;
	localparam int SCALE_W    = 16;
	localparam int WEIGHT_W   = 17;
	localparam int TICK_W     = 32;
	localparam int RATE_W     = 32;
	localparam int ANGLE_W    = 48;
	localparam int TIME_W     = 64;
	localparam int MUL_W      = 33;
	localparam int PROD_W     = 2 * MUL_W;
	localparam int N_AXES     = 3;
	localparam int AXIS_W     = 2;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	// default timer width
	localparam int COUNTER_BITS_DEF = 16;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_RATE_SCALE  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BIAS_X      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BIAS_Y      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BIAS_Z      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_WEIGHT      = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_TICK_PERIOD = 3'd5;

	// register values after reset
	localparam logic [SCALE_W-1:0]       RATE_SCALE_RST  = 16'd500;
	localparam logic signed [RATE_W-1:0] BIAS_X_RST      = 32'sd128001;
	localparam logic signed [RATE_W-1:0] BIAS_Y_RST      = -32'sd1500;
	localparam logic signed [RATE_W-1:0] BIAS_Z_RST      = 32'sd0;
	localparam logic [WEIGHT_W-1:0]      WEIGHT_RST      = 17'd19661;
	localparam logic [TICK_W-1:0]        TICK_PERIOD_RST = 32'd67109;

	// fixed-point limits
	localparam logic [WEIGHT_W-1:0]       WEIGHT_ONE = 17'd65536;
	localparam logic signed [RATE_W-1:0]  RATE_MAX   = 32'sh7FFF_FFFF;
	localparam logic signed [RATE_W-1:0]  RATE_MIN   = 32'sh8000_0000;
	localparam logic signed [ANGLE_W-1:0] ANGLE_MAX  = 48'sh7FFF_FFFF_FFFF;
	localparam logic signed [ANGLE_W-1:0] ANGLE_MIN  = 48'sh8000_0000_0000;
	localparam logic [TIME_W-1:0]         INC_LIMIT  = 64'h0002_0000_0000_0000;
	localparam logic [TIME_W-1:0]         LO_ROUND   = 64'h0000_0000_8000_0000;
	localparam int                        SMOOTH_ROUND = 32768;

	// multiplier operations issued by the controller
	typedef enum logic [2:0] {
		OP_NONE,
		OP_TIME,
		OP_RATE,
		OP_KEEP,
		OP_NEW,
		OP_LO,
		OP_HI
	} op_t;

	// commands from controller to datapath
	typedef struct packed {
		logic              load;
		op_t               op;
		logic [AXIS_W-1:0] axis;
		logic              out_load;
	} dp_cmd_t;

	// configuration register set
	typedef struct packed {
		logic [SCALE_W-1:0]       rate_scale;
		logic signed [RATE_W-1:0] bias_x;
		logic signed [RATE_W-1:0] bias_y;
		logic signed [RATE_W-1:0] bias_z;
		logic [WEIGHT_W-1:0]      smoothing_weight;
		logic [TICK_W-1:0]        tick_period;
	} cfg_t;

endpackage

// ----- rtl/core/gri_ctrl.sv -----
// sequencer for the shared multiplier and the handshakes of the gyro rate integrator
module gri_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	output gri_pkg::dp_cmd_t cmd
);

	// phases of one axis: multiplier issue slots
	localparam logic [2:0] PH_RATE = 3'd0;
	localparam logic [2:0] PH_KEEP = 3'd1;
	localparam logic [2:0] PH_NEW  = 3'd2;
	localparam logic [2:0] PH_LO   = 3'd5;
	localparam logic [2:0] PH_HI   = 3'd6;
	localparam logic [2:0] PH_LAST = 3'd6;
	localparam logic [2:0] TAIL_LAST = 3'd1;
	localparam logic [gri_pkg::AXIS_W-1:0] AXIS_LAST = 2'(gri_pkg::N_AXES - 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_TIME,
		S_AXIS,
		S_TAIL,
		S_DONE
	} state_t;

	state_t                     state_q;
	logic [2:0]                 phase_q;
	logic [gri_pkg::AXIS_W-1:0] axis_q;
	logic                       out_valid_q;
	logic                       done_load;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign done_load = (state_q == S_DONE) && (!out_valid_q || out_ready);

	// command decode
	always_comb begin
		cmd.load     = in_valid && (state_q == S_IDLE);
		cmd.out_load = done_load;
		cmd.axis     = axis_q;
		cmd.op       = gri_pkg::OP_NONE;
		unique case (state_q)
			S_TIME: begin
				cmd.op = gri_pkg::OP_TIME;
			end
			S_AXIS: begin
				unique case (phase_q)
					PH_RATE: cmd.op = gri_pkg::OP_RATE;
					PH_KEEP: cmd.op = gri_pkg::OP_KEEP;
					PH_NEW:  cmd.op = gri_pkg::OP_NEW;
					PH_LO:   cmd.op = gri_pkg::OP_LO;
					PH_HI:   cmd.op = gri_pkg::OP_HI;
					default: cmd.op = gri_pkg::OP_NONE;
				endcase
			end
			default: cmd.op = gri_pkg::OP_NONE;
		endcase
	end

	// state, counters and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			phase_q     <= '0;
			axis_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_TIME;
					end
				end
				S_TIME: begin
					state_q <= S_AXIS;
					phase_q <= '0;
					axis_q  <= '0;
				end
				S_AXIS: begin
					if (phase_q == PH_LAST) begin
						phase_q <= '0;
						if (axis_q == AXIS_LAST) begin
							state_q <= S_TAIL;
						end else begin
							axis_q <= axis_q + 2'd1;
						end
					end else begin
						phase_q <= phase_q + 3'd1;
					end
				end
				S_TAIL: begin
					if (phase_q == TAIL_LAST) begin
						state_q <= S_DONE;
					end else begin
						phase_q <= phase_q + 3'd1;
					end
				end
				S_DONE: begin
					if (done_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase

			if (done_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ----- rtl/core/gri_dp.sv -----
// datapath: shared multiplier, rate, smoothing and angle state of the gyro rate integrator
module gri_dp #(
	parameter int COUNTER_BITS = gri_pkg::COUNTER_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  gri_pkg::dp_cmd_t                   cmd,
	input  gri_pkg::cfg_t                      cfg,
	input  logic signed [gri_pkg::RAW_W-1:0]   raw_x,
	input  logic signed [gri_pkg::RAW_W-1:0]   raw_y,
	input  logic signed [gri_pkg::RAW_W-1:0]   raw_z,
	input  logic [gri_pkg::TIMER_W-1:0]        timer_count,
	output logic signed [gri_pkg::ANGLE_W-1:0] angle_x,
	output logic signed [gri_pkg::ANGLE_W-1:0] angle_y,
	output logic signed [gri_pkg::ANGLE_W-1:0] angle_z,
	output logic signed [gri_pkg::RATE_W-1:0]  smooth_rate_x,
	output logic signed [gri_pkg::RATE_W-1:0]  smooth_rate_y,
	output logic signed [gri_pkg::RATE_W-1:0]  smooth_rate_z
);

	// work after the product stage
	typedef enum logic [1:0] {
		POST_NONE,
		POST_MAG,
		POST_ANGLE
	} post_t;

	// sampled input item
	logic signed [gri_pkg::RAW_W-1:0]   raw_q [gri_pkg::N_AXES];
	logic [gri_pkg::TIMER_W-1:0]        timer_q;

	// per-axis state and the last timer count
	logic signed [gri_pkg::RATE_W-1:0]  smooth_q [gri_pkg::N_AXES];
	logic signed [gri_pkg::ANGLE_W-1:0] angle_q  [gri_pkg::N_AXES];
	logic [COUNTER_BITS-1:0]            last_q;

	// intermediate values
	logic [gri_pkg::TIME_W-1:0]         time_q;
	logic signed [gri_pkg::RATE_W-1:0]  r_q;
	logic signed [49:0]                 keep_q;
	logic [gri_pkg::RATE_W-1:0]         mag_q;
	logic                               neg_q;
	logic [31:0]                        lo_q;
	logic signed [50:0]                 inc_q;

	// pipeline of the shared multiplier
	gri_pkg::op_t                       op_s1;
	logic [gri_pkg::AXIS_W-1:0]         axis_s1;
	logic signed [gri_pkg::PROD_W-1:0]  prod_s1;
	post_t                              post_s2;
	logic [gri_pkg::AXIS_W-1:0]         axis_s2;

	// result register
	logic signed [gri_pkg::ANGLE_W-1:0] out_angle_q  [gri_pkg::N_AXES];
	logic signed [gri_pkg::RATE_W-1:0]  out_smooth_q [gri_pkg::N_AXES];

	logic [COUNTER_BITS-1:0]            now;
	logic [COUNTER_BITS-1:0]            ticks;
	logic [gri_pkg::WEIGHT_W-1:0]       w_clip;
	logic [gri_pkg::WEIGHT_W-1:0]       w_rest;
	logic signed [gri_pkg::MUL_W-1:0]   mul_a;
	logic signed [gri_pkg::MUL_W-1:0]   mul_b;
	logic signed [gri_pkg::RATE_W-1:0]  bias_sel;
	logic signed [33:0]                 rsum;
	logic signed [gri_pkg::RATE_W-1:0]  r_sat;
	logic signed [50:0]                 acc;
	logic signed [gri_pkg::RATE_W-1:0]  s_sat;
	logic [gri_pkg::RATE_W-1:0]         s_post;
	logic                               s_neg;
	logic [gri_pkg::RATE_W-1:0]         s_mag;
	logic [gri_pkg::TIME_W-1:0]         lo_sum;
	logic [gri_pkg::TIME_W-1:0]         inc_sum;
	logic [50:0]                        inc_ext;
	logic signed [51:0]                 asum;
	logic signed [gri_pkg::ANGLE_W-1:0] a_sat;

	// elapsed ticks modulo the counter range
	assign now   = COUNTER_BITS'(timer_q);
	assign ticks = now - last_q;

	// weight limited to one
	assign w_clip = (cfg.smoothing_weight > gri_pkg::WEIGHT_ONE) ?
		gri_pkg::WEIGHT_ONE : cfg.smoothing_weight;
	assign w_rest = gri_pkg::WEIGHT_ONE - w_clip;

	// operand selection for the shared multiplier
	always_comb begin
		unique case (cmd.op)
			gri_pkg::OP_TIME: begin
				mul_a = $signed({1'b0, 32'(ticks)});
				mul_b = $signed({1'b0, cfg.tick_period});
			end
			gri_pkg::OP_RATE: begin
				mul_a = gri_pkg::MUL_W'(raw_q[cmd.axis]);
				mul_b = $signed({17'b0, cfg.rate_scale});
			end
			gri_pkg::OP_KEEP: begin
				mul_a = gri_pkg::MUL_W'(smooth_q[cmd.axis]);
				mul_b = $signed({16'b0, w_rest});
			end
			gri_pkg::OP_NEW: begin
				mul_a = gri_pkg::MUL_W'(r_q);
				mul_b = $signed({16'b0, w_clip});
			end
			gri_pkg::OP_LO: begin
				mul_a = $signed({1'b0, mag_q});
				mul_b = $signed({1'b0, time_q[31:0]});
			end
			gri_pkg::OP_HI: begin
				mul_a = $signed({1'b0, mag_q});
				mul_b = $signed({1'b0, time_q[63:32]});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// bias of the axis whose product is in flight
	always_comb begin
		case (axis_s1)
			2'd0:    bias_sel = cfg.bias_x;
			2'd1:    bias_sel = cfg.bias_y;
			default: bias_sel = cfg.bias_z;
		endcase
	end

	// scaled rate plus bias, saturated
	assign rsum  = 34'($signed(prod_s1[32:0])) + 34'(bias_sel);
	assign r_sat = (rsum[33:31] == 3'b000 || rsum[33:31] == 3'b111) ? rsum[31:0] :
		(rsum[33] ? gri_pkg::RATE_MIN : gri_pkg::RATE_MAX);

	// moving average, round half up then floor by 2^16
	assign acc   = 51'(keep_q) + 51'($signed(prod_s1[49:0])) + 51'(gri_pkg::SMOOTH_ROUND);
	assign s_sat = (acc[50:47] == 4'b0000 || acc[50:47] == 4'b1111) ? acc[47:16] :
		(acc[50] ? gri_pkg::RATE_MIN : gri_pkg::RATE_MAX);

	// magnitude and sign of the smoothed rate
	assign s_post = smooth_q[axis_s2];
	assign s_neg  = s_post[31];
	assign s_mag  = s_neg ? (32'd0 - s_post) : s_post;

	// angle increment: rounded low product plus high product, limited
	assign lo_sum  = prod_s1[63:0] + gri_pkg::LO_ROUND;
	assign inc_sum = prod_s1[63:0] + {32'b0, lo_q};
	assign inc_ext = (inc_sum > gri_pkg::INC_LIMIT) ? {1'b0, gri_pkg::INC_LIMIT[49:0]} :
		{1'b0, inc_sum[49:0]};

	// angle accumulate, saturated
	assign asum  = 52'(angle_q[axis_s2]) + 52'(inc_q);
	assign a_sat = (asum[51:47] == 5'b00000 || asum[51:47] == 5'b11111) ? asum[47:0] :
		(asum[51] ? gri_pkg::ANGLE_MIN : gri_pkg::ANGLE_MAX);

	// state and pipeline control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < gri_pkg::N_AXES; i++) begin
				smooth_q[i] <= '0;
				angle_q[i]  <= '0;
			end
			last_q  <= '0;
			op_s1   <= gri_pkg::OP_NONE;
			post_s2 <= POST_NONE;
		end else begin
			op_s1 <= cmd.op;
			if (cmd.op == gri_pkg::OP_TIME) begin
				last_q <= now;
			end
			if (op_s1 == gri_pkg::OP_NEW) begin
				smooth_q[axis_s1] <= s_sat;
			end
			if (post_s2 == POST_ANGLE) begin
				angle_q[axis_s2] <= a_sat;
			end
			case (op_s1)
				gri_pkg::OP_NEW: post_s2 <= POST_MAG;
				gri_pkg::OP_HI:  post_s2 <= POST_ANGLE;
				default:         post_s2 <= POST_NONE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			raw_q[0] <= raw_x;
			raw_q[1] <= raw_y;
			raw_q[2] <= raw_z;
			timer_q  <= timer_count;
		end
		prod_s1 <= mul_a * mul_b;
		axis_s1 <= cmd.axis;
		axis_s2 <= axis_s1;
		case (op_s1)
			gri_pkg::OP_TIME: time_q <= prod_s1[63:0];
			gri_pkg::OP_RATE: r_q    <= r_sat;
			gri_pkg::OP_KEEP: keep_q <= prod_s1[49:0];
			gri_pkg::OP_LO:   lo_q   <= lo_sum[63:32];
			gri_pkg::OP_HI:   inc_q  <= neg_q ? $signed(51'd0 - inc_ext) : $signed(inc_ext);
			default: ;
		endcase
		if (post_s2 == POST_MAG) begin
			mag_q <= s_mag;
			neg_q <= s_neg;
		end
		if (cmd.out_load) begin
			for (int i = 0; i < gri_pkg::N_AXES; i++) begin
				out_angle_q[i]  <= angle_q[i];
				out_smooth_q[i] <= smooth_q[i];
			end
		end
	end

	assign angle_x       = out_angle_q[0];
	assign angle_y       = out_angle_q[1];
	assign angle_z       = out_angle_q[2];
	assign smooth_rate_x = out_smooth_q[0];
	assign smooth_rate_y = out_smooth_q[1];
	assign smooth_rate_z = out_smooth_q[2];

endmodule

// ----- rtl/core/gyro_rate_integrator.sv -----
// top level of the gyro rate integrator: configuration registers, controller and datapath
//
// Takes one three-axis gyro sample (raw_x/y/z, timer_count) per transfer on the
// in_valid/in_ready channel and returns one result (angle_x/y/z, smooth_rate_x/y/z)
// per transfer on the out_valid/out_ready channel. Per axis the raw value is scaled,
// biased, smoothed by a moving average and integrated over the elapsed timer ticks.
// The user must write registers through cfg_we/cfg_index/cfg_data only while no sample
// is in work; the block itself does not enforce it. A new sample is taken only once
// the block is idle again, as the single 33x33 multiplier serves the tick time and
// seven issue slots per axis in turn.
// The result sits in an output register; while it waits for out_ready the block
// accepts and works on the next sample, then holds that one until the register frees.
// Reset clears smoothed rates, angles and the last timer count to zero and loads the
// register defaults; the first sample measures its elapsed ticks from a count of zero.
module gyro_rate_integrator #(
	parameter int COUNTER_BITS = gri_pkg::COUNTER_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [gri_pkg::RAW_W-1:0]    raw_x,
	input  logic signed [gri_pkg::RAW_W-1:0]    raw_y,
	input  logic signed [gri_pkg::RAW_W-1:0]    raw_z,
	input  logic [gri_pkg::TIMER_W-1:0]         timer_count,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [gri_pkg::ANGLE_W-1:0]  angle_x,
	output logic signed [gri_pkg::ANGLE_W-1:0]  angle_y,
	output logic signed [gri_pkg::ANGLE_W-1:0]  angle_z,
	output logic signed [gri_pkg::RATE_W-1:0]   smooth_rate_x,
	output logic signed [gri_pkg::RATE_W-1:0]   smooth_rate_y,
	output logic signed [gri_pkg::RATE_W-1:0]   smooth_rate_z,
	input  logic                                cfg_we,
	input  logic [gri_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [gri_pkg::CFG_DATA_W-1:0]      cfg_data
);

	gri_pkg::cfg_t    cfg_q;
	gri_pkg::dp_cmd_t cmd;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rate_scale       <= gri_pkg::RATE_SCALE_RST;
			cfg_q.bias_x           <= gri_pkg::BIAS_X_RST;
			cfg_q.bias_y           <= gri_pkg::BIAS_Y_RST;
			cfg_q.bias_z           <= gri_pkg::BIAS_Z_RST;
			cfg_q.smoothing_weight <= gri_pkg::WEIGHT_RST;
			cfg_q.tick_period      <= gri_pkg::TICK_PERIOD_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				gri_pkg::REG_RATE_SCALE:  cfg_q.rate_scale       <= cfg_data[15:0];
				gri_pkg::REG_BIAS_X:      cfg_q.bias_x           <= $signed(cfg_data);
				gri_pkg::REG_BIAS_Y:      cfg_q.bias_y           <= $signed(cfg_data);
				gri_pkg::REG_BIAS_Z:      cfg_q.bias_z           <= $signed(cfg_data);
				gri_pkg::REG_WEIGHT:      cfg_q.smoothing_weight <= cfg_data[16:0];
				gri_pkg::REG_TICK_PERIOD: cfg_q.tick_period      <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencer
	gri_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	// arithmetic and state
	gri_dp #(
		.COUNTER_BITS (COUNTER_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.cfg           (cfg_q),
		.raw_x         (raw_x),
		.raw_y         (raw_y),
		.raw_z         (raw_z),
		.timer_count   (timer_count),
		.angle_x       (angle_x),
		.angle_y       (angle_y),
		.angle_z       (angle_z),
		.smooth_rate_x (smooth_rate_x),
		.smooth_rate_y (smooth_rate_y),
		.smooth_rate_z (smooth_rate_z)
	);

endmodule

// ----- bench/attitude_checker.sv -----
// channel monitor, attitude predictor and result comparison for the gyro rate integrator
module attitude_checker
	import gri_pkg::*;
#(
	parameter int COUNTER_BITS = COUNTER_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  logic                       in_ready,
	input  logic signed [RAW_W-1:0]    raw_x,
	input  logic signed [RAW_W-1:0]    raw_y,
	input  logic signed [RAW_W-1:0]    raw_z,
	input  logic [TIMER_W-1:0]         timer_count,
	input  logic                       out_valid,
	input  logic                       out_ready,
	input  logic signed [ANGLE_W-1:0]  angle_x,
	input  logic signed [ANGLE_W-1:0]  angle_y,
	input  logic signed [ANGLE_W-1:0]  angle_z,
	input  logic signed [RATE_W-1:0]   smooth_rate_x,
	input  logic signed [RATE_W-1:0]   smooth_rate_y,
	input  logic signed [RATE_W-1:0]   smooth_rate_z,
	input  logic                       cfg_we,
	input  logic [CFG_IDX_W-1:0]       cfg_index,
	input  logic [CFG_DATA_W-1:0]      cfg_data,
	output int                         mismatches,
	output int                         awaiting,
	output int                         samples_taken,
	output int                         results_checked
);
	timeunit 1ns;
	timeprecision 1ps;

	// one predicted result: angles and smoothed rates per axis
	typedef struct packed {
		logic [N_AXES-1:0][ANGLE_W-1:0] angle;
		logic [N_AXES-1:0][RATE_W-1:0]  rate;
	} attitude_t;

	// predictor state and its own copy of the registers
	cfg_t                     regs;
	logic signed [RATE_W-1:0]  avg_rate  [N_AXES];
	logic signed [ANGLE_W-1:0] angle_acc [N_AXES];
	logic [COUNTER_BITS-1:0]   prev_count;
	attitude_t                 pending_attitudes [$];

	int    errs;
	int    taken;
	int    checked;
	string axis_tag = "xyz";

	// outputs gathered per axis for comparison
	logic signed [ANGLE_W-1:0] seen_angle [N_AXES];
	logic signed [RATE_W-1:0]  seen_rate  [N_AXES];

	assign seen_angle[0] = angle_x;
	assign seen_angle[1] = angle_y;
	assign seen_angle[2] = angle_z;
	assign seen_rate[0]  = smooth_rate_x;
	assign seen_rate[1]  = smooth_rate_y;
	assign seen_rate[2]  = smooth_rate_z;

	// scale, bias, smooth and integrate one axis
	function automatic void advance_axis(input int k, input logic signed [RAW_W-1:0] raw,
			input logic signed [RATE_W-1:0] bias, input logic [TIME_W-1:0] elapsed);
		longint     rate;
		longint     w;
		longint     acc;
		longint     s;
		longint     a;
		logic       neg;
		logic [63:0] mag;
		logic [63:0] p;
		logic [63:0] q;
		logic [63:0] inc;
		rate = longint'(raw) * longint'({1'b0, regs.rate_scale}) + longint'(bias);
		if (rate > longint'(RATE_MAX)) rate = longint'(RATE_MAX);
		if (rate < longint'(RATE_MIN)) rate = longint'(RATE_MIN);

		// weight above one acts as one
		w = (regs.smoothing_weight > WEIGHT_ONE) ? longint'(WEIGHT_ONE)
			: longint'(regs.smoothing_weight);
		acc = (65536 - w) * longint'(avg_rate[k]) + w * rate + SMOOTH_ROUND;
		s = acc >>> 16;
		if (s > longint'(RATE_MAX)) s = longint'(RATE_MAX);
		if (s < longint'(RATE_MIN)) s = longint'(RATE_MIN);
		avg_rate[k] = s[RATE_W-1:0];

		// magnitude times elapsed time, rounded half away from zero
		neg = (s < 0);
		mag = neg ? 64'(-s) : 64'(s);
		p = mag * {32'd0, elapsed[31:0]};
		q = mag * {32'd0, elapsed[63:32]};
		inc = q + ((p + LO_ROUND) >> 32);
		if (inc > INC_LIMIT) inc = INC_LIMIT;

		a = longint'(angle_acc[k]) + (neg ? -longint'(inc) : longint'(inc));
		if (a > longint'(ANGLE_MAX)) a = longint'(ANGLE_MAX);
		if (a < longint'(ANGLE_MIN)) a = longint'(ANGLE_MIN);
		angle_acc[k] = a[ANGLE_W-1:0];
	endfunction

	// expected result of one sample; advances the predictor state
	function automatic attitude_t integrate_sample(input logic signed [RAW_W-1:0] rx,
			input logic signed [RAW_W-1:0] ry, input logic signed [RAW_W-1:0] rz,
			input logic [TIMER_W-1:0] tc);
		logic [COUNTER_BITS-1:0] now;
		logic [COUNTER_BITS-1:0] ticks;
		logic [TIME_W-1:0]       elapsed;
		attitude_t               res;
		now = COUNTER_BITS'(tc);
		ticks = now - prev_count;
		elapsed = TIME_W'(ticks) * TIME_W'(regs.tick_period);
		advance_axis(0, rx, regs.bias_x, elapsed);
		advance_axis(1, ry, regs.bias_y, elapsed);
		advance_axis(2, rz, regs.bias_z, elapsed);
		prev_count = now;
		for (int k = 0; k < N_AXES; k++) begin
			res.angle[k] = angle_acc[k];
			res.rate[k]  = avg_rate[k];
		end
		return res;
	endfunction

	function automatic int field_differs(input string field, input longint want,
			input longint got);
		if (want == got)
			return 0;
		$error("%s: expected %0d, got %0d", field, want, got);
		return 1;
	endfunction

	// watch register writes and both channels
	always @(posedge clk or negedge arst_n) begin : watch
		attitude_t want;
		if (!arst_n) begin
			regs = '{rate_scale: RATE_SCALE_RST, bias_x: BIAS_X_RST, bias_y: BIAS_Y_RST,
				bias_z: BIAS_Z_RST, smoothing_weight: WEIGHT_RST,
				tick_period: TICK_PERIOD_RST};
			for (int k = 0; k < N_AXES; k++) begin
				avg_rate[k]  = '0;
				angle_acc[k] = '0;
			end
			prev_count = '0;
			pending_attitudes.delete();
			errs = 0;
			taken = 0;
			checked = 0;
		end else begin
			// register writes, out-of-range indexes do nothing
			if (cfg_we) begin
				case (cfg_index)
					REG_RATE_SCALE:  regs.rate_scale       = cfg_data[SCALE_W-1:0];
					REG_BIAS_X:      regs.bias_x           = cfg_data[RATE_W-1:0];
					REG_BIAS_Y:      regs.bias_y           = cfg_data[RATE_W-1:0];
					REG_BIAS_Z:      regs.bias_z           = cfg_data[RATE_W-1:0];
					REG_WEIGHT:      regs.smoothing_weight = cfg_data[WEIGHT_W-1:0];
					REG_TICK_PERIOD: regs.tick_period      = cfg_data[TICK_W-1:0];
					default: ;
				endcase
			end

			// sample transfer
			if (in_valid && in_ready) begin
				pending_attitudes.push_back(integrate_sample(raw_x, raw_y, raw_z,
					timer_count));
				taken++;
			end

			// result transfer
			if (out_valid && out_ready) begin
				checked++;
				if (pending_attitudes.size() == 0) begin
					errs++;
					$error("result transfer with no sample awaiting it");
				end else begin
					want = pending_attitudes.pop_front();
					for (int k = 0; k < N_AXES; k++) begin
						errs += field_differs($sformatf("angle_%c", axis_tag[k]),
							longint'($signed(want.angle[k])), longint'(seen_angle[k]));
						errs += field_differs($sformatf("smooth_rate_%c", axis_tag[k]),
							longint'($signed(want.rate[k])), longint'(seen_rate[k]));
					end
				end
			end
		end
		mismatches      <= errs;
		awaiting        <= pending_attitudes.size();
		samples_taken   <= taken;
		results_checked <= checked;
	end

endmodule

// ----- bench/tb.sv -----
// testbench top of the gyro rate integrator: stimulus, idling and verdict
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import gri_pkg::*;

	localparam int COUNTER_BITS  = COUNTER_BITS_DEF;
	localparam int RANDOM_PHASES = 8;
	localparam int PHASE_ITEMS   = 135;
	localparam int HOLD_PHASE    = 2;
	localparam int LONG_HOLD     = 300;
	localparam int SETTLE_CYCLES = 40;

	logic                      clk         = 1'b0;
	logic                      arst_n      = 1'b0;
	logic                      in_valid    = 1'b0;
	logic                      in_ready;
	logic signed [RAW_W-1:0]   raw_x       = '0;
	logic signed [RAW_W-1:0]   raw_y       = '0;
	logic signed [RAW_W-1:0]   raw_z       = '0;
	logic [TIMER_W-1:0]        timer_count = '0;
	logic                      out_valid;
	logic                      out_ready   = 1'b0;
	logic signed [ANGLE_W-1:0] angle_x;
	logic signed [ANGLE_W-1:0] angle_y;
	logic signed [ANGLE_W-1:0] angle_z;
	logic signed [RATE_W-1:0]  smooth_rate_x;
	logic signed [RATE_W-1:0]  smooth_rate_y;
	logic signed [RATE_W-1:0]  smooth_rate_z;
	logic                      cfg_we      = 1'b0;
	logic [CFG_IDX_W-1:0]      cfg_index   = '0;
	logic [CFG_DATA_W-1:0]     cfg_data    = '0;

	int mismatches;
	int awaiting;
	int samples_taken;
	int results_checked;

	// idling control shared by sender and receiver
	logic               calm      = 1'b0;
	int                 hold_req  = 0;
	int                 hold_done = 0;
	logic [TIMER_W-1:0] last_tc   = '0;
	int                 settings_used = 1;

	gyro_rate_integrator #(.COUNTER_BITS(COUNTER_BITS)) dut (.*);

	attitude_checker #(.COUNTER_BITS(COUNTER_BITS)) checker_i (.*);

	// 100 MHz clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// watchdog
	initial begin
		#(5_000_000);
		$display("gyro_rate_integrator regression: fail");
		$finish;
	end

	// receiver: random stalls, one long hold-off on request
	initial begin : drain
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (hold_req != hold_done) begin
				out_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				hold_done <= hold_done + 1;
				out_ready <= 1'b1;
			end else if (!calm && $urandom_range(0, 9) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 15)) @(posedge clk);
				out_ready <= 1'b1;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// offer one sample, return at the edge of its transfer
	task automatic send_sample(input logic signed [RAW_W-1:0] rx,
			input logic signed [RAW_W-1:0] ry, input logic signed [RAW_W-1:0] rz,
			input logic [TIMER_W-1:0] tc);
		if (!calm && hold_req == hold_done && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		in_valid    <= 1'b1;
		raw_x       <= rx;
		raw_y       <= ry;
		raw_z       <= rz;
		timer_count <= tc;
		last_tc = tc;
		do
			@(posedge clk);
		while (!in_ready);
	endtask

	// drop valid, wait for every result, then let the block go quiet
	task automatic settle();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (awaiting != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// write all registers, then the two unused indexes
	task automatic load_settings(input cfg_t s);
		logic [CFG_IDX_W-1:0]  idx  [8];
		logic [CFG_DATA_W-1:0] data [8];
		idx[0] = REG_RATE_SCALE;  data[0] = CFG_DATA_W'(s.rate_scale);
		idx[1] = REG_BIAS_X;      data[1] = s.bias_x;
		idx[2] = REG_BIAS_Y;      data[2] = s.bias_y;
		idx[3] = REG_BIAS_Z;      data[3] = s.bias_z;
		idx[4] = REG_WEIGHT;      data[4] = CFG_DATA_W'(s.smoothing_weight);
		idx[5] = REG_TICK_PERIOD; data[5] = s.tick_period;
		idx[6] = REG_TICK_PERIOD + 3'd1; data[6] = $urandom;
		idx[7] = REG_TICK_PERIOD + 3'd2; data[7] = $urandom;
		for (int i = 0; i < 8; i++) begin
			@(posedge clk);
			cfg_we    <= 1'b1;
			cfg_index <= idx[i];
			cfg_data  <= data[i];
		end
		@(posedge clk);
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	function automatic logic signed [RAW_W-1:0] pick_raw();
		case ($urandom_range(0, 7))
			0: return 16'sh7FFF;
			1: return 16'sh8000;
			2: return RAW_W'(int'($urandom_range(0, 64)) - 32);
			default: return RAW_W'($urandom);
		endcase
	endfunction

	function automatic logic signed [RATE_W-1:0] pick_bias();
		case ($urandom_range(0, 5))
			0: return RATE_MAX;
			1: return RATE_MIN;
			2: return '0;
			3: return RATE_W'($urandom);
			default: return RATE_W'(int'($urandom_range(0, 2_000_000)) - 1_000_000);
		endcase
	endfunction

	// register setting with a bias towards the extremes
	function automatic cfg_t random_setting();
		cfg_t s;
		case ($urandom_range(0, 3))
			0: s.rate_scale = '0;
			1: s.rate_scale = '1;
			default: s.rate_scale = SCALE_W'($urandom);
		endcase
		s.bias_x = pick_bias();
		s.bias_y = pick_bias();
		s.bias_z = pick_bias();
		case ($urandom_range(0, 5))
			0: s.smoothing_weight = '0;
			1: s.smoothing_weight = WEIGHT_ONE;
			2: s.smoothing_weight = '1;
			3: s.smoothing_weight = WEIGHT_W'($urandom);
			default: s.smoothing_weight = WEIGHT_W'($urandom_range(0, 65536));
		endcase
		case ($urandom_range(0, 5))
			0: s.tick_period = '0;
			1: s.tick_period = '1;
			2: s.tick_period = $urandom;
			default: s.tick_period = $urandom_range(1, 1 << 24);
		endcase
		return s;
	endfunction

	initial begin : stimulus
		logic [TIMER_W-1:0] tc;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset defaults: first sample from count zero, equal counts, wrap
		send_sample(16'sd0, 16'sd0, 16'sd0, 16'd100);
		send_sample(16'sh7FFF, 16'sh8000, 16'sd0, 16'd100);
		send_sample(16'sh8000, 16'sh7FFF, -16'sd1, 16'hFFFF);
		send_sample(16'sd1, -16'sd1, 16'sd12345, 16'd5);
		send_sample(16'sd300, 16'sd300, -16'sd300, 16'd5);
		settle();

		// full scale with weight above one: rates and angles saturate both ways
		load_settings('{rate_scale: 16'hFFFF, bias_x: RATE_MAX, bias_y: RATE_MIN,
			bias_z: 32'sd0, smoothing_weight: 17'h1FFFF, tick_period: 32'hFFFF_FFFF});
		send_sample(16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'hFFFF);
		send_sample(16'sh7FFF, 16'sh8000, 16'sh8000, 16'hFFFE);
		send_sample(16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'hFFFD);
		send_sample(16'sh8000, 16'sh7FFF, 16'sh8000, 16'hFFFC);
		send_sample(16'sh8000, 16'sh7FFF, 16'sh8000, 16'hFFFB);
		send_sample(16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'hFFFB);
		settle();

		// zero scale, weight and period: angles hold, rates frozen
		load_settings('{rate_scale: 16'd0, bias_x: -32'sd1, bias_y: 32'sd1,
			bias_z: RATE_MAX, smoothing_weight: 17'd0, tick_period: 32'd0});
		send_sample(16'sh7FFF, 16'sh8000, 16'sd7, 16'd0);
		send_sample(16'sh8000, 16'sh7FFF, -16'sd7, 16'd40000);
		send_sample(16'sd0, 16'sd0, 16'sd0, 16'd39999);
		settle();

		// weight exactly one, single unit scale and period
		load_settings('{rate_scale: 16'd1, bias_x: 32'sd0, bias_y: RATE_MIN,
			bias_z: -32'sd65536, smoothing_weight: WEIGHT_ONE, tick_period: 32'd1});
		send_sample(16'sd1, -16'sd1, 16'sh7FFF, 16'd1);
		send_sample(-16'sd2, 16'sd2, 16'sh8000, 16'd0);
		send_sample(16'sh5555, 16'shAAAA, 16'sd0, 16'hFFFF);
		settle();

		// random register settings, mostly advancing timer counts
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			load_settings(random_setting());
			if (p == HOLD_PHASE)
				hold_req <= hold_req + 1;
			if (p == RANDOM_PHASES - 1)
				calm <= 1'b1;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				case ($urandom_range(0, 15))
					0: tc = last_tc;
					1: tc = TIMER_W'($urandom);
					2: tc = last_tc - TIMER_W'($urandom_range(1, 50));
					default: tc = last_tc + TIMER_W'($urandom_range(1, 2000));
				endcase
				send_sample(pick_raw(), pick_raw(), pick_raw(), tc);
			end
			settle();
		end

		$display("%0d samples over %0d register settings, %0d results compared",
			samples_taken, settings_used, results_checked);
		$display("covered saturation both ways, frozen and full weight, timer wrap and a long output stall");
		if (mismatches == 0 && awaiting == 0)
			$display("gyro_rate_integrator regression: pass");
		else
			$display("gyro_rate_integrator regression: fail");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/core/gri_pkg.sv
rtl/core/gri_ctrl.sv
rtl/core/gri_dp.sv
rtl/core/gyro_rate_integrator.sv
bench/attitude_checker.sv
bench/tb.sv
